// File: src/tslfo_pkg.sv
// ---------------------------------------------------------------------------
// tslfo_pkg: shared types, constants and table builders
// Types, widths and elaboration-time table functions for the tempo-synced LFO.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tslfo_pkg;

   // Field and register widths
   localparam int ELAPSED_W  = 20;
   localparam int BPM_W      = 8;
   localparam int BPC_W      = 11;
   localparam int DEPTH_W    = 7;
   localparam int SAMPLE_W   = 16;
   localparam int RAW_W      = 17;
   localparam int PHASE_W    = 32;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;

   // Shared multiplier: 33-bit signed by 18-bit signed
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Increment divider: floor((bpm * elapsed) << 28 / (234375 * bpc))
   localparam int NUM_W      = 28;
   localparam int DEN_W      = 29;
   localparam int FRAC_SHIFT = 28;
   localparam int DIV_STEPS  = NUM_W + FRAC_SHIFT;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam logic [17:0] DEN_UNIT = 18'd234375;

   // Reset values of the registers
   localparam logic [BPM_W-1:0]   BPM_RESET   = 8'd120;
   localparam logic [BPC_W-1:0]   BPC_RESET   = 11'd16;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd0;

   // Pulse levels, +/- 1.0 in Q2.15 (one bit wider than a table word)
   localparam logic [RAW_W-1:0] PULSE_HIGH = 17'h08000;
   localparam logic [RAW_W-1:0] PULSE_LOW  = 17'h18000;

   // Table-building constants
   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMPO_BPM       = 2'd0,
      CSR_BEATS_PER_CYCLE = 2'd1,
      CSR_WAVE_SHAPE      = 2'd2,
      CSR_MOD_DEPTH       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_TRIANGLE = 2'd1,
      SHAPE_SAW      = 2'd2,
      SHAPE_PULSE    = 2'd3
   } wave_shape_type;

   typedef enum logic [2:0] {
      MUL_POS,
      MUL_INTERP,
      MUL_SCALE,
      MUL_NUM,
      MUL_DEN
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_RDA,
      ST_RDB,
      ST_INTERP,
      ST_SCALE,
      ST_NUM,
      ST_DEN,
      ST_DIV
   } lfo_state_type;

   // Operand sources for the shared multiplier
   typedef struct packed {
      logic [PHASE_W-1:0]   phase;
      logic [RAW_W-1:0]     diff;
      logic [15:0]          frac;
      logic [RAW_W-1:0]     raw;
      logic [DEPTH_W-1:0]   depth;
      logic [ELAPSED_W-1:0] elapsed;
      logic [BPM_W-1:0]     bpm;
      logic [BPC_W-1:0]     bpc;
   } mul_src_type;

   // Divider status back to the sequencer
   typedef struct packed {
      logic               done;
      logic [PHASE_W-1:0] quotient;
   } div_status_type;

   // Sine word at phase p: Taylor series to x^9 in Q30, rounded to Q15
   function automatic logic [15:0] sine_word(input logic [31:0] p);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] v;
      logic [15:0] w;
      r = {34'd0, p[29:0]};
      if (p[30]) begin
         r = {32'd0, ONE_Q30} - r;
      end
      x   = (r * {32'd0, HALF_PI_Q30}) >> 30;
      x2  = (x * x) >> 30;
      sum = x;
      t   = ((x * x2) >> 30) / 64'd6;
      sum = sum - t;
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + t;
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - t;
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + t;
      v   = (sum + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      w = v[15:0];
      if (p[31]) begin
         w = 16'(~w + 16'd1);
      end
      return w;
   endfunction

   // Triangle word at phase p
   function automatic logic [15:0] tri_word(input logic [31:0] p);
      logic [30:0] m;
      logic [15:0] v;
      m = {1'b0, p[29:0]};
      if (p[30]) begin
         m = ONE_Q30[30:0] - m;
      end
      v = m[30:15];
      if (v > 16'd32767) begin
         v = 16'd32767;
      end
      if (p[31]) begin
         v = 16'(~v + 16'd1);
      end
      return v;
   endfunction

endpackage

// File: src/tslfo_rom.sv
// ---------------------------------------------------------------------------
// tslfo_rom: waveform tables
// Sine, triangle and sawtooth Q1.15 tables built at elaboration, one
// registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tslfo_rom #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                              clock,
   input  tslfo_pkg::wave_shape_type         rd_shape,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]  rd_index,
   output logic [15:0]                       rd_data
);
   import tslfo_pkg::*;

   logic [15:0] sine_tbl [TABLE_ENTRIES];
   logic [15:0] tri_tbl  [TABLE_ENTRIES];
   logic [15:0] saw_tbl  [TABLE_ENTRIES];
   logic [15:0] rd_data_ff;

   // Entry i sits at phase floor(i * 2^32 / TABLE_ENTRIES)
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
      localparam logic [63:0] PH64 = (64'(i) << 32) / TABLE_ENTRIES;
      localparam logic [31:0] PH   = PH64[31:0];
      assign sine_tbl[i] = sine_word(PH);
      assign tri_tbl[i]  = tri_word(PH);
      assign saw_tbl[i]  = PH[31:16];
   end

   // Registered read
   always_ff @(posedge clock) begin
      case (rd_shape)
         SHAPE_SINE:     rd_data_ff <= sine_tbl[rd_index];
         SHAPE_TRIANGLE: rd_data_ff <= tri_tbl[rd_index];
         SHAPE_SAW:      rd_data_ff <= saw_tbl[rd_index];
         default:        rd_data_ff <= '0;
      endcase
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tslfo_mul.sv
// ---------------------------------------------------------------------------
// tslfo_mul: shared multiplier
// One signed 33x18 multiplier; the sequencer's operation code picks the
// operand pair for each step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tslfo_mul #(
   parameter int TABLE_ENTRIES = 256
) (
   input  tslfo_pkg::mul_op_type                op,
   input  tslfo_pkg::mul_src_type               src,
   output logic signed [tslfo_pkg::PROD_W-1:0]  product
);
   import tslfo_pkg::*;

   localparam logic [MUL_B_W-1:0] ENTRIES_B = MUL_B_W'(TABLE_ENTRIES);

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;

   // Operand select
   always_comb begin
      case (op)
         MUL_POS: begin
            op_a = {1'b0, src.phase};
            op_b = ENTRIES_B;
         end
         MUL_INTERP: begin
            op_a = {{(MUL_A_W-RAW_W){src.diff[RAW_W-1]}}, src.diff};
            op_b = {2'b00, src.frac};
         end
         MUL_SCALE: begin
            op_a = {{(MUL_A_W-RAW_W){src.raw[RAW_W-1]}}, src.raw};
            op_b = {{(MUL_B_W-DEPTH_W){1'b0}}, src.depth};
         end
         MUL_NUM: begin
            op_a = {{(MUL_A_W-ELAPSED_W){1'b0}}, src.elapsed};
            op_b = {{(MUL_B_W-BPM_W){1'b0}}, src.bpm};
         end
         MUL_DEN: begin
            op_a = {{(MUL_A_W-18){1'b0}}, DEN_UNIT};
            op_b = {{(MUL_B_W-BPC_W){1'b0}}, src.bpc};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign product = op_a * op_b;

endmodule

// File: src/tslfo_div.sv
// ---------------------------------------------------------------------------
// tslfo_div: phase increment divider
// Restoring division, one quotient bit per cycle, of num * 2^28 by den.
// Keeps the low 32 quotient bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tslfo_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tslfo_pkg::NUM_W-1:0]     num,
   input  logic [tslfo_pkg::DEN_W-1:0]     den,
   output tslfo_pkg::div_status_type       status
);
   import tslfo_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [NUM_W-1:0]     dvd_ff, dvd_in;
   logic [PHASE_W-1:0]   quot_ff, quot_in;

   logic [DEN_W:0]       rem_sh;
   logic                 fits;
   logic                 busy;

   // One compare-subtract step
   assign busy   = (cnt_ff != '0);
   assign rem_sh = {rem_ff, dvd_ff[NUM_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      if (start) begin
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = '0;
         den_in  = den;
         dvd_in  = num;
         quot_in = '0;
      end else if (busy) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
         rem_in  = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         dvd_in  = {dvd_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[PHASE_W-2:0], fits};
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule

// File: src/tempo_synced_lfo_core.sv
// ---------------------------------------------------------------------------
// tempo_synced_lfo_core: tempo-synced wavetable LFO
// Sine, triangle and sawtooth requests step through position, table reads,
// interpolation and depth scaling; pulse or zero depth goes straight to
// scaling, which registers the result once any earlier one is taken. No new
// request is taken until the 56 divider steps end (none at zero depth or bpc).
// Reset: synchronous; registers return to 120 bpm, 16/16 beats, sine, depth 0,
// phase 0. The tables are constant, so no fill pass follows reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tempo_synced_lfo_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tslfo_pkg::ELAPSED_W-1:0]        req_elapsed_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tslfo_pkg::SAMPLE_W-1:0]  rsp_mod_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tslfo_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tslfo_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tslfo_pkg::*;

   localparam int INDEX_W = $clog2(TABLE_ENTRIES);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(TABLE_ENTRIES - 1);

   // Sequencer and configuration
   lfo_state_type        state_ff, state_in;
   logic [BPM_W-1:0]     bpm_ff, bpm_in;
   logic [BPC_W-1:0]     bpc_ff, bpc_in;
   wave_shape_type       shape_ff, shape_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Per-transaction datapath
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [15:0]          frac_ff, frac_in;
   logic [SAMPLE_W-1:0]  a_ff, a_in;
   logic [RAW_W-1:0]     raw_ff, raw_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [SAMPLE_W-1:0]  rsp_value_ff, rsp_value_in;

   // Control
   logic                 req_take;
   logic                 csr_write;
   logic                 rsp_load;
   logic                 div_start;
   logic                 phase_add;
   mul_op_type           mul_op;
   logic [INDEX_W-1:0]   rom_index;
   logic [INDEX_W-1:0]   idx_next;

   // Shared units
   mul_src_type                 mul_src;
   logic signed [PROD_W-1:0]    product;
   logic [SAMPLE_W-1:0]         rom_data;
   div_status_type              div_status;
   logic [RAW_W:0]              interp_sum;
   logic [24:0]                 scaled;

   assign req_take  = req_valid && req_ready;
   assign csr_write = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (depth_ff == '0 || shape_ff == SHAPE_PULSE) begin
                  state_in = ST_SCALE;
               end else begin
                  state_in = ST_POS;
               end
            end
         end
         ST_POS:    state_in = ST_RDA;
         ST_RDA:    state_in = ST_RDB;
         ST_RDB:    state_in = ST_INTERP;
         ST_INTERP: state_in = ST_SCALE;
         ST_SCALE: begin
            if (rsp_load) begin
               state_in = (depth_ff == '0) ? ST_IDLE : ST_NUM;
            end
         end
         ST_NUM:    state_in = ST_DEN;
         ST_DEN:    state_in = (bpc_ff == '0) ? ST_IDLE : ST_DIV;
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      div_start = 1'b0;
      phase_add = 1'b0;
      mul_op    = MUL_POS;
      rom_index = idx_ff;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_POS:    mul_op = MUL_POS;
         ST_RDA:    rom_index = idx_ff;
         ST_RDB:    rom_index = idx_next;
         ST_INTERP: mul_op = MUL_INTERP;
         ST_SCALE: begin
            mul_op   = MUL_SCALE;
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         ST_NUM:    mul_op = MUL_NUM;
         ST_DEN: begin
            mul_op    = MUL_DEN;
            div_start = (bpc_ff != '0);
         end
         ST_DIV:    phase_add = div_status.done;
         default:   req_ready = 1'b0;
      endcase
   end

   // Table neighbor, wrapping after the last entry
   assign idx_next = (idx_ff == LAST_INDEX) ? '0 : idx_ff + 1'b1;

   // Multiplier operands
   always_comb begin
      mul_src.phase   = phase_ff;
      mul_src.diff    = {rom_data[SAMPLE_W-1], rom_data} - {a_ff[SAMPLE_W-1], a_ff};
      mul_src.frac    = frac_ff;
      mul_src.raw     = raw_ff;
      mul_src.depth   = depth_ff;
      mul_src.elapsed = elapsed_ff;
      mul_src.bpm     = bpm_ff;
      mul_src.bpc     = bpc_ff;
   end

   // a + floor((b - a) * frac / 65536), and rounded depth scaling
   assign interp_sum = product[33:16] + {{2{a_ff[SAMPLE_W-1]}}, a_ff};
   assign scaled     = product[24:0] + 25'd64;

   // Datapath next values
   always_comb begin
      elapsed_in   = elapsed_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      a_in         = a_ff;
      raw_in       = raw_ff;
      num_in       = num_ff;
      rsp_value_in = rsp_value_ff;
      if (req_take) begin
         elapsed_in = req_elapsed_us;
         raw_in     = phase_ff[PHASE_W-1] ? PULSE_LOW : PULSE_HIGH;
      end
      if (state_ff == ST_POS) begin
         idx_in  = product[32 +: INDEX_W];
         frac_in = product[31:16];
      end
      if (state_ff == ST_RDB) begin
         a_in = rom_data;
      end
      if (state_ff == ST_INTERP) begin
         raw_in = interp_sum[RAW_W-1:0];
      end
      if (state_ff == ST_NUM) begin
         num_in = product[NUM_W-1:0];
      end
      if (rsp_load) begin
         rsp_value_in = scaled[22:7];
      end
   end

   // Configuration, phase and result valid
   always_comb begin
      bpm_in       = bpm_ff;
      bpc_in       = bpc_ff;
      shape_in     = shape_ff;
      depth_in     = depth_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (phase_add) begin
         phase_in = phase_ff + div_status.quotient;
      end
      if (csr_write) begin
         case (csr_index)
            CSR_TEMPO_BPM: begin
               bpm_in   = csr_wdata[BPM_W-1:0];
               phase_in = '0;
            end
            CSR_BEATS_PER_CYCLE: begin
               bpc_in   = csr_wdata[BPC_W-1:0];
               phase_in = '0;
            end
            CSR_WAVE_SHAPE: begin
               shape_in = wave_shape_type'(csr_wdata[1:0]);
               phase_in = '0;
            end
            CSR_MOD_DEPTH: begin
               depth_in = csr_wdata[DEPTH_W-1:0];
            end
            default: begin
               depth_in = depth_ff;
            end
         endcase
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bpm_ff       <= BPM_RESET;
         bpc_ff       <= BPC_RESET;
         shape_ff     <= SHAPE_SINE;
         depth_ff     <= DEPTH_RESET;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bpm_ff       <= bpm_in;
         bpc_ff       <= bpc_in;
         shape_ff     <= shape_in;
         depth_ff     <= depth_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      elapsed_ff   <= elapsed_in;
      idx_ff       <= idx_in;
      frac_ff      <= frac_in;
      a_ff         <= a_in;
      raw_ff       <= raw_in;
      num_ff       <= num_in;
      rsp_value_ff <= rsp_value_in;
   end

   tslfo_mul #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_mul (
      .op      (mul_op),
      .src     (mul_src),
      .product (product)
   );

   tslfo_rom #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_rom (
      .clock    (clock),
      .rd_shape (shape_ff),
      .rd_index (rom_index),
      .rd_data  (rom_data)
   );

   tslfo_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_ff),
      .den    (product[DEN_W-1:0]),
      .status (div_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mod_value = rsp_value_ff;

   // Checks
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after a request transaction");

   a_zero_depth_mutes: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && depth_ff == '0) |=> rsp_mod_value == '0)
      else $error("nonzero result at zero depth");

   a_phase_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !csr_write) |=> $stable(phase_ff))
      else $error("phase moved while idle");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

endmodule
